>>> hw/rtl/stroke_line_rasterizer_unit_defines.svh
// assertion macros for the checker file of stroke_line_rasterizer_unit
// depends on: nothing; the user provides clk and rst_n in scope
`ifndef STROKE_LINE_RASTERIZER_UNIT_DEFINES_SVH
`define STROKE_LINE_RASTERIZER_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define SLR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define SLR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/slr_pkg.sv
// shared types and constants of the stroke line rasterizer
// depends on: nothing
`timescale 1ns / 1ps
`default_nettype none

package slr_pkg;

    localparam int COORD_W    = 6;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W     = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int ERR_W      = COORD_W + 3;

    typedef logic [COORD_W-1:0] coord_t;

    // highest point index of one segment
    localparam coord_t LAST_INDEX = {COORD_W{1'b1}};

    // one segment handed from front to engine
    typedef struct packed {
        coord_t start_x;
        coord_t start_y;
        coord_t end_x;
        coord_t end_y;
    } seg_cmd_t;

    typedef enum logic [1:0] {
        ENG_IDLE = 2'b01,
        ENG_RUN  = 2'b10
    } eng_state_t;

endpackage

`default_nettype wire

>>> hw/rtl/slr_front.sv
// front end: accepts pen events, keeps pen state and anchor, issues segments
// depends on: slr_pkg
`timescale 1ns / 1ps
`default_nettype none

module slr_front #(
    parameter int GRID_SIZE = 64
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  in_valid,
    output logic                 in_ready,
    input  wire                  pen_down,
    input  wire slr_pkg::coord_t cell_x,
    input  wire slr_pkg::coord_t cell_y,
    output logic                 push_valid,
    input  wire                  push_ready,
    output slr_pkg::seg_cmd_t    push_cmd
);

    // saturation value for cells past the grid edge
    localparam slr_pkg::coord_t COORD_MAX = (GRID_SIZE > (1 << slr_pkg::COORD_W))
        ? {slr_pkg::COORD_W{1'b1}} : slr_pkg::COORD_W'(GRID_SIZE - 1);
    localparam int CMP_W = slr_pkg::COORD_W + 12;

    logic            pen_active_reg, pen_active_next;
    slr_pkg::coord_t anchor_x_reg, anchor_x_next;
    slr_pkg::coord_t anchor_y_reg, anchor_y_next;
    slr_pkg::coord_t tgt_x, tgt_y;
    logic            accept;

    always_comb
    begin
        tgt_x = (CMP_W'(cell_x) >= CMP_W'(GRID_SIZE)) ? COORD_MAX : cell_x;
        tgt_y = (CMP_W'(cell_y) >= CMP_W'(GRID_SIZE)) ? COORD_MAX : cell_y;
    end

    assign in_ready   = push_ready;
    assign accept     = in_valid && in_ready;
    assign push_valid = accept && pen_down && pen_active_reg;
    assign push_cmd   = '{start_x: anchor_x_reg, start_y: anchor_y_reg,
                          end_x: tgt_x, end_y: tgt_y};

    always_comb
    begin
        pen_active_next = pen_active_reg;
        anchor_x_next   = anchor_x_reg;
        anchor_y_next   = anchor_y_reg;
        if (accept)
        begin
            pen_active_next = pen_down;
            if (pen_down)
            begin
                anchor_x_next = tgt_x;
                anchor_y_next = tgt_y;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pen_active_reg <= 1'b0;
            anchor_x_reg   <= '0;
            anchor_y_reg   <= '0;
        end
        else
        begin
            pen_active_reg <= pen_active_next;
            anchor_x_reg   <= anchor_x_next;
            anchor_y_reg   <= anchor_y_next;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/slr_queue.sv
// short segment queue between front end and line engine
// depends on: slr_pkg
`timescale 1ns / 1ps
`default_nettype none

module slr_queue (
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire                      push_valid,
    output logic                     push_ready,
    input  wire slr_pkg::seg_cmd_t   push_cmd,
    output logic                     pop_valid,
    input  wire                      pop_ready,
    output slr_pkg::seg_cmd_t        pop_cmd
);

    slr_pkg::seg_cmd_t               entry_reg [slr_pkg::QUEUE_DEPTH];
    logic [slr_pkg::QPTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [slr_pkg::QPTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [slr_pkg::QCNT_W-1:0]      count_reg, count_next;
    logic                            do_push, do_pop;

    assign push_ready = (count_reg != slr_pkg::QCNT_W'(slr_pkg::QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // pointer wrap at the queue depth
    function automatic logic [slr_pkg::QPTR_W-1:0] ptr_inc(
        input logic [slr_pkg::QPTR_W-1:0] p
    );
        return (p == slr_pkg::QPTR_W'(slr_pkg::QUEUE_DEPTH - 1))
            ? '0 : p + slr_pkg::QPTR_W'(1);
    endfunction

    always_comb
    begin
        wr_ptr_next = do_push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = do_pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + slr_pkg::QCNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - slr_pkg::QCNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

`default_nettype wire

>>> hw/rtl/slr_engine.sv
// line engine: walks one segment per command, one point per cycle unless the output stalls
// depends on: slr_pkg
`timescale 1ns / 1ps
`default_nettype none

module slr_engine (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    cmd_valid,
    output logic                   cmd_ready,
    input  wire slr_pkg::seg_cmd_t cmd,
    output logic                   out_valid,
    input  wire                    out_ready,
    output slr_pkg::coord_t        point_x,
    output slr_pkg::coord_t        point_y,
    output logic                   last_point
);

    localparam int E2_W = slr_pkg::ERR_W + 1;

    slr_pkg::eng_state_t           state_reg, state_next;
    slr_pkg::coord_t               x_reg, x_next, y_reg, y_next;
    slr_pkg::coord_t               tx_reg, tx_next, ty_reg, ty_next;
    slr_pkg::coord_t               dx_reg, dx_next, dy_reg, dy_next;
    logic                          sx_neg_reg, sx_neg_next, sy_neg_reg, sy_neg_next;
    logic signed [slr_pkg::ERR_W-1:0] err_reg, err_next;
    slr_pkg::coord_t               n_reg, n_next;
    logic                          out_valid_reg, out_valid_next;
    slr_pkg::coord_t               px_reg, px_next, py_reg, py_next;
    logic                          last_reg, last_next;

    logic                          out_free, emit, seg_done, step_x, step_y;
    logic signed [E2_W-1:0]        e2, dx_s, dy_s;
    slr_pkg::coord_t               ldx, ldy;

    assign out_valid  = out_valid_reg;
    assign point_x    = px_reg;
    assign point_y    = py_reg;
    assign last_point = last_reg;

    assign out_free  = !out_valid_reg || out_ready;
    assign cmd_ready = (state_reg == slr_pkg::ENG_IDLE);
    assign emit      = (state_reg == slr_pkg::ENG_RUN) && out_free;
    assign seg_done  = ((x_reg == tx_reg) && (y_reg == ty_reg))
                       || (n_reg == slr_pkg::LAST_INDEX);

    // error step decisions
    assign e2     = {err_reg, 1'b0};
    assign dx_s   = $signed(E2_W'(dx_reg));
    assign dy_s   = $signed(E2_W'(dy_reg));
    assign step_x = (e2 > -dy_s);
    assign step_y = (e2 < dx_s);

    assign ldx = (cmd.end_x >= cmd.start_x) ? cmd.end_x - cmd.start_x
                                            : cmd.start_x - cmd.end_x;
    assign ldy = (cmd.end_y >= cmd.start_y) ? cmd.end_y - cmd.start_y
                                            : cmd.start_y - cmd.end_y;

    always_comb
    begin
        state_next     = state_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        tx_next        = tx_reg;
        ty_next        = ty_reg;
        dx_next        = dx_reg;
        dy_next        = dy_reg;
        sx_neg_next    = sx_neg_reg;
        sy_neg_next    = sy_neg_reg;
        err_next       = err_reg;
        n_next         = n_reg;
        out_valid_next = out_valid_reg && !out_ready;
        px_next        = px_reg;
        py_next        = py_reg;
        last_next      = last_reg;

        unique case (state_reg)
            slr_pkg::ENG_IDLE:
            begin
                if (cmd_valid)
                begin
                    x_next      = cmd.start_x;
                    y_next      = cmd.start_y;
                    tx_next     = cmd.end_x;
                    ty_next     = cmd.end_y;
                    dx_next     = ldx;
                    dy_next     = ldy;
                    sx_neg_next = !(cmd.start_x < cmd.end_x);
                    sy_neg_next = !(cmd.start_y < cmd.end_y);
                    err_next    = $signed(slr_pkg::ERR_W'(ldx))
                                  - $signed(slr_pkg::ERR_W'(ldy));
                    n_next      = '0;
                    state_next  = slr_pkg::ENG_RUN;
                end
            end
            slr_pkg::ENG_RUN:
            begin
                if (emit)
                begin
                    out_valid_next = 1'b1;
                    px_next        = x_reg;
                    py_next        = y_reg;
                    last_next      = seg_done;
                    n_next         = n_reg + slr_pkg::COORD_W'(1);
                    if (seg_done)
                        state_next = slr_pkg::ENG_IDLE;
                    else
                    begin
                        err_next = err_reg
                            - (step_x ? $signed(slr_pkg::ERR_W'(dy_reg)) : '0)
                            + (step_y ? $signed(slr_pkg::ERR_W'(dx_reg)) : '0);
                        if (step_x)
                            x_next = sx_neg_reg ? x_reg - slr_pkg::COORD_W'(1)
                                                : x_reg + slr_pkg::COORD_W'(1);
                        if (step_y)
                            y_next = sy_neg_reg ? y_reg - slr_pkg::COORD_W'(1)
                                                : y_reg + slr_pkg::COORD_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = slr_pkg::ENG_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= slr_pkg::ENG_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg      <= x_next;
        y_reg      <= y_next;
        tx_reg     <= tx_next;
        ty_reg     <= ty_next;
        dx_reg     <= dx_next;
        dy_reg     <= dy_next;
        sx_neg_reg <= sx_neg_next;
        sy_neg_reg <= sy_neg_next;
        err_reg    <= err_next;
        n_reg      <= n_next;
        px_reg     <= px_next;
        py_reg     <= py_next;
        last_reg   <= last_next;
    end

endmodule

`default_nettype wire

>>> hw/rtl/stroke_line_rasterizer_unit.sv
// stroke line rasterizer: pen events in, bresenham line points out
// first point: once its pen event is accepted, a segment passes the queue register,
// the engine setup state and the output register, when the engine is idle
// throughput: set by the line engine, a setup state per segment of N points (N up to 64),
// then one point per cycle unless the output stalls; events that draw nothing are not queued
// reset: rst_n asynchronous, active low; pen up, anchor at cell 0,0, queue and output empty
`timescale 1ns / 1ps
`default_nettype none

module stroke_line_rasterizer_unit #(
    parameter int GRID_SIZE = 64
) (
    input  wire                  clk,
    input  wire                  rst_n,

    // pen event channel, one transaction per event
    input  wire                  in_valid,
    output logic                 in_ready,
    input  wire                  pen_down,
    input  wire slr_pkg::coord_t cell_x,
    input  wire slr_pkg::coord_t cell_y,

    // line point channel, one transaction per point
    output logic                 out_valid,
    input  wire                  out_ready,
    output slr_pkg::coord_t      point_x,
    output slr_pkg::coord_t      point_y,
    output logic                 last_point
);

    // segment commands front -> queue
    logic              push_valid;
    logic              push_ready;
    slr_pkg::seg_cmd_t push_cmd;

    // segment commands queue -> engine
    logic              cmd_valid;
    logic              cmd_ready;
    slr_pkg::seg_cmd_t cmd;

    // front end: tracks pen state and anchor, turns each pen-down event
    // after the first into a segment command; pen-up and first-down events
    // only update state and are never queued
    slr_front #(
        .GRID_SIZE (GRID_SIZE)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .pen_down   (pen_down),
        .cell_x     (cell_x),
        .cell_y     (cell_y),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd)
    );

    // two-entry queue lets the front keep taking events while the engine
    // walks a long segment or the output is stalled
    slr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (cmd_valid),
        .pop_ready  (cmd_ready),
        .pop_cmd    (cmd)
    );

    // line engine: an IDLE setup state per segment, then one point per cycle
    // into a registered output stage that holds under backpressure
    slr_engine u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_ready  (cmd_ready),
        .cmd        (cmd),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .point_x    (point_x),
        .point_y    (point_y),
        .last_point (last_point)
    );

endmodule

`default_nettype wire

>>> hw/rtl/slr_checker.sv
// port-level checks for stroke_line_rasterizer_unit, bound to the top level
// depends on: slr_pkg, stroke_line_rasterizer_unit_defines.svh
`timescale 1ns / 1ps
`default_nettype none
`include "stroke_line_rasterizer_unit_defines.svh"

module slr_checker #(
    parameter int GRID_SIZE = 64
) (
    input wire                  clk,
    input wire                  rst_n,
    input wire                  in_valid,
    input wire                  in_ready,
    input wire                  out_valid,
    input wire                  out_ready,
    input wire slr_pkg::coord_t point_x,
    input wire slr_pkg::coord_t point_y,
    input wire                  last_point
);

    localparam int CMP_W = slr_pkg::COORD_W + 12;

    logic x_in_grid, y_in_grid;

    assign x_in_grid = (CMP_W'(point_x) < CMP_W'(GRID_SIZE));
    assign y_in_grid = (CMP_W'(point_y) < CMP_W'(GRID_SIZE));

    // a stalled point holds its payload
    `SLR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(point_x) && $stable(point_y) && $stable(last_point), "stalled point changed")

    // inside a segment the next point follows in the very next cycle
    `SLR_ASSERT_NEXT(a_seg_gapless, out_valid && out_ready && !last_point, out_valid, "gap inside a segment")

    // every point lies on the grid
    `SLR_ASSERT_NOW(a_on_grid, out_valid, x_in_grid && y_in_grid, "point off the grid")

    // the front stays ready while no event comes in and no point is out
    `SLR_ASSERT_NEXT(a_ready_when_empty, !in_valid && !out_valid && $past(!out_valid) && in_ready, in_ready, "input blocked while idle")

endmodule

bind stroke_line_rasterizer_unit slr_checker #(
    .GRID_SIZE (GRID_SIZE)
) u_slr_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .point_x    (point_x),
    .point_y    (point_y),
    .last_point (last_point)
);

`default_nettype wire
